>>> rtl/tdq_pkg.sv
package tdq_pkg;

  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_PUSH  = 3'd1,
    FUNC_POP   = 3'd2,
    FUNC_CLEAR = 3'd3,
    FUNC_CLOSE = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_DUE = 2'd1,
    ST_CLOSED  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_WR,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DN_CMP2,
    S_DONE
  } state_t;

endpackage

>>> rtl/tdq_heap_mem.sv
module tdq_heap_mem #(
  parameter int ENT_W = 96,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ENT_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ENT_W-1:0]  rd_data
);

  logic [ENT_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/timed_delay_queue.sv
// Bounded delay queue kept as a min-heap on (due time, push order) in one
// synchronous memory with a registered read. The root entry is mirrored in
// registers, so the pop check and the ready flag need no read. One item is
// handled at a time, and a new item is taken only after the result has left.
// Steps from one accept to the next:
//   - tick, clear, close, unused codes and a rejected push or pop: straight
//     to the result
//   - a push: a parent read and compare per level it climbs, then a write
//     where it stops
//   - a pop that empties the queue: a read of the last slot, then the result
//   - any other pop: the last entry is moved to the root and sinks level by
//     level (left read, right read, pick, write)
// One read port, hence separate reads. Equal due times leave in push order.
module timed_delay_queue #(
  parameter int CAPACITY = 64,
  parameter int VALUE_W = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_item_value,
  input  logic [19:0] in_delay_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_out_value,
  output logic [1:0]  out_status,
  output logic [6:0]  out_fill_count,
  output logic        out_is_ready,
  output logic        out_is_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = VALUE_W + 64;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [31:0]        due;
    logic [31:0]        order;
  } ent_t;

  tdq_pkg::state_t state_r, state_nxt;

  logic [31:0] time_r;
  logic [CW-1:0] cnt_r;
  logic [31:0] order_r;
  logic closed_r;
  ent_t root_r;
  ent_t cur_r;          // entry being sifted
  ent_t chl_r;          // left child of the current slot
  ent_t best_r;
  logic use_rgt_r;
  logic [AW-1:0] idx_r;
  logic [31:0] res_val_r;
  logic [1:0]  res_st_r;

  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  ent_t mem_wd, mem_rd;

  tdq_heap_mem #(.ENT_W(EW), .ADDR_W(AW)) u_mem (
    .clk(clk), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
    .rd_addr(mem_ra), .rd_data(mem_rd)
  );

  function automatic logic earlier(ent_t a, ent_t b);
    if (a.due != b.due) return a.due < b.due;
    return a.order < b.order;
  endfunction

  logic [32:0] due_sum;
  assign due_sum = {1'b0, time_r} + {13'd0, in_delay_ticks};

  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != tdq_pkg::S_IDLE) || out_valid;

  logic push_ok, pop_ok;
  assign push_ok = (in_func == tdq_pkg::FUNC_PUSH) && !closed_r &&
                   (cnt_r < CW'(CAPACITY));
  assign pop_ok = (in_func == tdq_pkg::FUNC_POP) && !closed_r && (cnt_r != '0) &&
                  (root_r.due <= time_r);

  tdq_pkg::status_t acc_st;
  always_comb begin
    acc_st = tdq_pkg::ST_OK;
    if (((in_func == tdq_pkg::FUNC_PUSH) || (in_func == tdq_pkg::FUNC_POP)) && closed_r)
      acc_st = tdq_pkg::ST_CLOSED;
    else if ((in_func == tdq_pkg::FUNC_PUSH) && !push_ok)
      acc_st = tdq_pkg::ST_FULL;
    else if ((in_func == tdq_pkg::FUNC_POP) && !pop_ok)
      acc_st = tdq_pkg::ST_NOT_DUE;
  end

  // heap index arithmetic, sized one bit wider so children past the end are seen
  logic [AW:0] lidx, ridx;
  assign lidx = {idx_r, 1'b1};
  assign ridx = {idx_r, 1'b0} + (AW+1)'(2);
  logic [AW-1:0] parent;
  assign parent = (idx_r - AW'(1)) >> 1;

  logic lft_ok, rgt_ok, use_rgt, up_move, dn_move;
  ent_t best;
  assign lft_ok = lidx < (AW+1)'(cnt_r);
  assign rgt_ok = ridx < (AW+1)'(cnt_r);
  assign use_rgt = rgt_ok && earlier(mem_rd, chl_r);
  assign best = use_rgt ? mem_rd : chl_r;
  assign up_move = earlier(cur_r, mem_rd);
  assign dn_move = earlier(best_r, cur_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdq_pkg::S_IDLE: begin
        if (in_acc) begin
          if (push_ok)     state_nxt = tdq_pkg::S_UP_RD;
          else if (pop_ok) state_nxt = tdq_pkg::S_POP_RD;
          else             state_nxt = tdq_pkg::S_DONE;
        end
      end
      tdq_pkg::S_UP_RD:   state_nxt = (idx_r == '0) ? tdq_pkg::S_DONE : tdq_pkg::S_UP_CMP;
      tdq_pkg::S_UP_CMP:  state_nxt = up_move ? tdq_pkg::S_UP_RD : tdq_pkg::S_DONE;
      tdq_pkg::S_POP_RD:  state_nxt = (cnt_r == '0) ? tdq_pkg::S_DONE : tdq_pkg::S_POP_WR;
      tdq_pkg::S_POP_WR:  state_nxt = tdq_pkg::S_DN_RDL;
      tdq_pkg::S_DN_RDL:  state_nxt = lft_ok ? tdq_pkg::S_DN_RDR : tdq_pkg::S_DONE;
      tdq_pkg::S_DN_RDR:  state_nxt = tdq_pkg::S_DN_CMP;
      tdq_pkg::S_DN_CMP:  state_nxt = tdq_pkg::S_DN_CMP2;
      tdq_pkg::S_DN_CMP2: state_nxt = dn_move ? tdq_pkg::S_DN_RDL : tdq_pkg::S_DONE;
      tdq_pkg::S_DONE:    state_nxt = tdq_pkg::S_IDLE;
      default:            state_nxt = tdq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = cur_r;
    mem_ra = idx_r;
    case (state_r)
      tdq_pkg::S_UP_RD: begin
        mem_ra = parent;
        mem_we = (idx_r == '0);   // new entry reached the root
      end
      tdq_pkg::S_UP_CMP: begin
        // parent moves down into this slot, or the new entry settles here
        mem_we = 1'b1;
        if (up_move) mem_wd = mem_rd;
      end
      tdq_pkg::S_POP_RD:  mem_ra = cnt_r[AW-1:0];
      tdq_pkg::S_DN_RDL: begin
        mem_ra = lidx[AW-1:0];
        mem_we = !lft_ok;         // leaf reached
      end
      tdq_pkg::S_DN_RDR:  mem_ra = ridx[AW-1:0];
      tdq_pkg::S_DN_CMP2: begin
        mem_we = 1'b1;
        if (dn_move) mem_wd = best_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdq_pkg::S_IDLE;
      time_r <= '0;
      cnt_r <= '0;
      order_r <= '0;
      closed_r <= 1'b0;
      out_valid <= 1'b0;
      root_r <= '0;
      idx_r <= '0;
      res_val_r <= '0;
      res_st_r <= tdq_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      if (state_r == tdq_pkg::S_DONE) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      // keep the root mirror in step with every write to slot zero
      if (mem_we && (mem_wa == '0)) root_r <= mem_wd;
      case (state_r)
        tdq_pkg::S_IDLE: if (in_acc) begin
          res_st_r <= acc_st;
          res_val_r <= pop_ok ? 32'(root_r.value) : '0;
          case (in_func)
            tdq_pkg::FUNC_TICK: if (time_r != '1) time_r <= time_r + 32'd1;
            tdq_pkg::FUNC_PUSH: if (push_ok) begin
              cur_r.value <= VALUE_W'(in_item_value);
              cur_r.due <= due_sum[32] ? '1 : due_sum[31:0];
              cur_r.order <= order_r;
              order_r <= order_r + 32'd1;
              idx_r <= AW'(cnt_r);
              cnt_r <= cnt_r + CW'(1);
            end
            tdq_pkg::FUNC_POP: if (pop_ok) cnt_r <= cnt_r - CW'(1);
            tdq_pkg::FUNC_CLEAR: cnt_r <= '0;
            tdq_pkg::FUNC_CLOSE: begin
              cnt_r <= '0;
              closed_r <= 1'b1;
            end
            default: ;
          endcase
        end
        tdq_pkg::S_UP_CMP: if (up_move) idx_r <= parent;
        tdq_pkg::S_POP_WR: begin
          cur_r <= mem_rd;   // last entry starts at the root
          idx_r <= '0;
        end
        tdq_pkg::S_DN_RDR: chl_r <= mem_rd;
        tdq_pkg::S_DN_CMP: begin
          best_r <= best;
          use_rgt_r <= use_rgt;
        end
        tdq_pkg::S_DN_CMP2: begin
          if (dn_move) idx_r <= use_rgt_r ? ridx[AW-1:0] : lidx[AW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign out_out_value = res_val_r;
  assign out_status = res_st_r;
  assign out_fill_count = 7'(cnt_r);
  assign out_is_empty = (cnt_r == '0);
  assign out_is_ready = (cnt_r != '0) && (root_r.due <= time_r);

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_acc) else $error("item accepted while busy");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("fill count over capacity");
  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (closed_r && state_r == tdq_pkg::S_IDLE) |-> cnt_r == '0)
    else $error("closed queue holds entries");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_out_value) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = 64;

  typedef struct {
    logic [31:0]      value;
    tdq_pkg::status_t status;
    logic [6:0]       fill;
    logic             ready;
    logic             empty;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = tdq_pkg::FUNC_TICK;
  logic [31:0] in_item_value = '0;
  logic [19:0] in_delay_ticks = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_out_value;
  logic [1:0]  out_status;
  logic [6:0]  out_fill_count;
  logic        out_is_ready;
  logic        out_is_empty;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int pops_released = 0;
  int full_rejects = 0;

  // shadow of the heap and its bookkeeping
  logic [31:0] heap_val [DEPTH];
  logic [31:0] heap_due [DEPTH];
  logic [31:0] heap_ord [DEPTH];
  int          held;
  logic [31:0] now_ticks;
  logic [31:0] order_next;
  logic        is_closed;
  result_t     expected_results[$];

  timed_delay_queue u_top (.*);

  always #4 clk = ~clk;

  function automatic bit leaves_first(int a, int b);
    if (heap_due[a] != heap_due[b]) return heap_due[a] < heap_due[b];
    return heap_ord[a] < heap_ord[b];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [31:0] v, d, o;
    v = heap_val[a]; d = heap_due[a]; o = heap_ord[a];
    heap_val[a] = heap_val[b]; heap_due[a] = heap_due[b]; heap_ord[a] = heap_ord[b];
    heap_val[b] = v; heap_due[b] = d; heap_ord[b] = o;
  endfunction

  function automatic result_t queue_predict(logic [2:0] f, logic [31:0] v, logic [19:0] dl);
    result_t r;
    int i, p, l, best;
    logic [32:0] due;
    r.value = '0;
    r.status = tdq_pkg::ST_OK;
    case (f)
      tdq_pkg::FUNC_TICK: if (now_ticks != 32'hFFFF_FFFF) now_ticks++;
      tdq_pkg::FUNC_PUSH: begin
        if (is_closed) r.status = tdq_pkg::ST_CLOSED;
        else if (held >= DEPTH) r.status = tdq_pkg::ST_FULL;
        else begin
          due = {1'b0, now_ticks} + dl;
          i = held;
          heap_val[i] = v;
          heap_due[i] = due[32] ? 32'hFFFF_FFFF : due[31:0];
          heap_ord[i] = order_next;
          order_next++;
          held++;
          while (i > 0) begin
            p = (i - 1) / 2;
            if (!leaves_first(i, p)) break;
            swap_slots(i, p);
            i = p;
          end
        end
      end
      tdq_pkg::FUNC_POP: begin
        if (is_closed) r.status = tdq_pkg::ST_CLOSED;
        else if (held == 0 || heap_due[0] > now_ticks) r.status = tdq_pkg::ST_NOT_DUE;
        else begin
          r.value = heap_val[0];
          held--;
          if (held > 0) begin
            swap_slots(0, held);
            i = 0;
            forever begin
              l = 2 * i + 1;
              best = i;
              if (l < held && leaves_first(l, best)) best = l;
              if (l + 1 < held && leaves_first(l + 1, best)) best = l + 1;
              if (best == i) break;
              swap_slots(i, best);
              i = best;
            end
          end
        end
      end
      tdq_pkg::FUNC_CLEAR: held = 0;
      tdq_pkg::FUNC_CLOSE: begin
        held = 0;
        is_closed = 1'b1;
      end
      default: ;
    endcase
    r.fill = held[6:0];
    r.ready = held > 0 && heap_due[0] <= now_ticks;
    r.empty = held == 0;
    return r;
  endfunction

  task automatic send_item(logic [2:0] f, logic [31:0] v = '0, logic [19:0] dl = '0);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_item_value <= v;
    in_delay_ticks <= dl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = queue_predict(f, v, dl);
    if (f == tdq_pkg::FUNC_POP && r.status == tdq_pkg::ST_OK) pops_released++;
    if (r.status == tdq_pkg::ST_FULL) full_rejects++;
    expected_results.push_back(r);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stall and result check
  always @(posedge clk) begin
    result_t e;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, nothing pending");
      end else begin
        e = expected_results.pop_front();
        if (out_out_value !== e.value || out_status !== e.status ||
            out_fill_count !== e.fill || out_is_ready !== e.ready ||
            out_is_empty !== e.empty) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp val=%h st=%0d fill=%0d rdy=%b emp=%b",
                     e.value, e.status, e.fill, e.ready, e.empty);
            $display("          got val=%h st=%0d fill=%0d rdy=%b emp=%b",
                     out_out_value, out_status, out_fill_count, out_is_ready,
                     out_is_empty);
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_item(tdq_pkg::FUNC_POP);
    send_item(tdq_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 20'd0);
    send_item(tdq_pkg::FUNC_POP);
    send_item(tdq_pkg::FUNC_PUSH, 32'h0, 20'hFFFFF);
    send_item(tdq_pkg::FUNC_TICK);
    send_item(tdq_pkg::FUNC_POP);
    // equal due times must leave in push order
    send_item(tdq_pkg::FUNC_PUSH, 32'hA5A5_0001, 20'd2);
    send_item(tdq_pkg::FUNC_PUSH, 32'h5A5A_0002, 20'd2);
    send_item(tdq_pkg::FUNC_PUSH, 32'h1234_0003, 20'd2);
    send_item(tdq_pkg::FUNC_PUSH, 32'h0F0F_0004, 20'd1);
    send_item(tdq_pkg::FUNC_TICK);
    send_item(tdq_pkg::FUNC_POP);
    send_item(tdq_pkg::FUNC_POP);
    send_item(tdq_pkg::FUNC_TICK);
    send_item(tdq_pkg::FUNC_POP);
    send_item(tdq_pkg::FUNC_POP);
    send_item(tdq_pkg::FUNC_POP);
    send_item(tdq_pkg::FUNC_POP);
    for (int c = int'(tdq_pkg::FUNC_CLOSE) + 1; c < 8; c++)
      send_item(3'(c), $urandom, 20'(c));
    send_item(tdq_pkg::FUNC_CLEAR);
    send_item(tdq_pkg::FUNC_TICK);
  endtask

  task automatic test_fill_to_capacity();
    for (int k = 0; k < DEPTH; k++)
      send_item(tdq_pkg::FUNC_PUSH, $urandom, 20'($urandom_range(0, 3)));
    send_item(tdq_pkg::FUNC_PUSH, $urandom, 20'd0);
    repeat (4) send_item(tdq_pkg::FUNC_TICK);
    repeat (DEPTH / 2) send_item(tdq_pkg::FUNC_POP);
    send_item(tdq_pkg::FUNC_CLEAR);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 28) send_item(tdq_pkg::FUNC_TICK);
    else if (pick < 60)
      send_item(tdq_pkg::FUNC_PUSH, $urandom, ($urandom_range(9) == 0) ? 20'($urandom) :
                20'($urandom_range(0, 6)));
    else if (pick < 94) send_item(tdq_pkg::FUNC_POP);
    else if (pick < 96) send_item(tdq_pkg::FUNC_CLEAR);
    else if (pick < 98)
      send_item(3'($urandom_range(7, int'(tdq_pkg::FUNC_CLOSE) + 1)), $urandom,
                20'($urandom));
    else begin
      // burst of pushes to run into the capacity limit
      repeat ($urandom_range(10, 70))
        send_item(tdq_pkg::FUNC_PUSH, $urandom, 20'($urandom_range(0, 4)));
    end
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) random_item();
  endtask

  task automatic test_closed();
    send_item(tdq_pkg::FUNC_PUSH, $urandom, 20'd0);
    send_item(tdq_pkg::FUNC_CLOSE);
    send_item(tdq_pkg::FUNC_PUSH, $urandom, 20'd0);
    send_item(tdq_pkg::FUNC_POP);
    send_item(tdq_pkg::FUNC_TICK);
    send_item(tdq_pkg::FUNC_CLEAR);
    send_item(tdq_pkg::FUNC_CLOSE);
    for (int k = 0; k < 20; k++) random_item();
  endtask

  initial begin
    held = 0;
    now_ticks = '0;
    order_next = '0;
    is_closed = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 24;
    recv_stall_pct = 61;
    test_directed();
    wait_drained();
    test_fill_to_capacity();
    test_random(280);
    wait_drained();
    send_idle_pct = 61;
    recv_stall_pct = 24;
    test_random(280);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(280);
    test_closed();
    wait_drained();
    repeat (60) @(posedge clk);
    $display("sent %0d items, checked %0d results: %0d pops released, %0d full rejects",
             items_sent, results_seen, pops_released, full_rejects);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d results pending", expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
